[rtl/cscd_pkg.sv]
// Shared types, codes and frame unpacking for the CAN signal change decoder.
// No dependencies; every other file in rtl/ imports this package.
package cscd_pkg;

	localparam int IdW      = 11;
	localparam int NumSig   = 9;
	localparam int MaxEvent = 4;
	localparam int QDepth   = 4;
	localparam int QPtrW    = $clog2(QDepth);
	localparam int CntW     = $clog2(MaxEvent + 1);

	// Signal codes, also the bit positions of the event masks.
	typedef enum logic [3:0] {
		SIG_SPEED       = 4'd0,
		SIG_DISTANCE    = 4'd1,
		SIG_LIMIT       = 4'd2,
		SIG_LIGHT       = 4'd3,
		SIG_FREQUENCY   = 4'd4,
		SIG_VALVE_STATE = 4'd5,
		SIG_VALVE_KEY   = 4'd6,
		SIG_POSITION    = 4'd7,
		SIG_TIME        = 4'd8
	} sig_code_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_SPEED_ID     = 3'd0,
		CFG_STATE_ID     = 3'd1,
		CFG_ODOMETER_ID  = 3'd2,
		CFG_FREQUENCY_ID = 3'd3,
		CFG_POSITION_ID  = 3'd4,
		CFG_CLOCK_ID     = 3'd5,
		CFG_EVENT_ENABLE = 3'd6
	} cfg_idx_t;

	typedef logic [7:0][7:0] frame_bytes_t;

	// All signal values carried by one frame, whatever its identifier.
	typedef struct packed {
		logic [15:0] speed;
		logic [23:0] distance;
		logic [15:0] limit;
		logic [3:0]  light;
		logic [1:0]  frequency;
		logic        valve_state;
		logic        valve_key;
		logic [31:0] latitude;
		logic [30:0] longitude;
		logic [7:0]  hours;
		logic [7:0]  minutes;
		logic [7:0]  seconds;
	} frame_vals_t;

	// One queued frame: which events remain to be sent, and its data bytes.
	typedef struct packed {
		logic [NumSig-1:0] mask;
		frame_bytes_t      bytes;
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_wr_t;

	function automatic frame_vals_t decode_frame(input frame_bytes_t b);
		frame_vals_t v;
		// Speed: byte0 integer part with byte1 bit 0 as the top bit, byte1[7:1]
		// as seven fraction bits.
		v.speed       = {b[1][0], b[0], b[1][7:1]};
		v.distance    = {b[5], b[3], b[4]};
		v.limit       = {b[3][7], 7'd0, b[1]};
		v.light       = b[5][3:0];
		v.frequency   = b[4][5:4];
		v.valve_state = b[5][5];
		v.valve_key   = b[0][6];
		v.latitude    = {b[3], b[2], b[1], b[0]};
		v.longitude   = {b[7][6:0], b[6], b[5], b[4]};
		v.hours       = b[4];
		v.minutes     = b[5];
		v.seconds     = b[6];
		return v;
	endfunction

endpackage

[rtl/cscd_front.sv]
// Front end: configuration registers, identifier match, change detection and
// last-value storage. Depends on cscd_pkg; feeds cscd_queue.
module cscd_front import cscd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // [10:0] can_id, [74:11] byte0..byte7, [79:75] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        q_full,
	output q_wr_t       q_wr
);

	logic [IdW-1:0]    speed_id_q, state_id_q, odo_id_q, freq_id_q, pos_id_q, clk_id_q;
	logic [NumSig-1:0] enable_q;

	logic [15:0] last_speed_q;
	logic [23:0] last_distance_q;
	logic [15:0] last_limit_q;
	logic [3:0]  last_light_q;
	logic [1:0]  last_frequency_q;
	logic        last_valve_state_q;
	logic        last_valve_key_q;
	logic [31:0] last_latitude_q;
	logic [30:0] last_longitude_q;
	logic [7:0]  last_hours_q, last_minutes_q, last_seconds_q;

	logic [IdW-1:0]    can_id;
	frame_bytes_t      bytes;
	frame_vals_t       vals;
	logic              accept;
	logic              hit_speed, hit_state, hit_odo, hit_freq, hit_pos, hit_clk;
	logic [NumSig-1:0] changed, raw_mask, kept_mask;
	logic [CntW-1:0]   kept_cnt;

	assign can_id    = s_tdata[IdW-1:0];
	assign bytes     = s_tdata[IdW+63:IdW];
	assign vals      = decode_frame(bytes);
	assign s_tready  = !q_full;
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;

	assign hit_speed = (can_id == speed_id_q);
	assign hit_state = (can_id == state_id_q);
	assign hit_odo   = (can_id == odo_id_q);
	assign hit_freq  = (can_id == freq_id_q);
	assign hit_pos   = (can_id == pos_id_q);
	assign hit_clk   = (can_id == clk_id_q);

	always_comb begin
		changed[SIG_SPEED]       = hit_speed && (vals.speed != last_speed_q);
		changed[SIG_DISTANCE]    = hit_odo && (vals.distance != last_distance_q);
		changed[SIG_LIMIT]       = hit_state && (vals.limit != last_limit_q);
		changed[SIG_LIGHT]       = hit_state && (vals.light != last_light_q);
		changed[SIG_FREQUENCY]   = hit_freq && (vals.frequency != last_frequency_q);
		changed[SIG_VALVE_STATE] = hit_state && (vals.valve_state != last_valve_state_q);
		changed[SIG_VALVE_KEY]   = hit_state && (vals.valve_key != last_valve_key_q);
		changed[SIG_POSITION]    = hit_pos && ((vals.latitude != last_latitude_q) ||
			(vals.longitude != last_longitude_q));
		changed[SIG_TIME]        = hit_clk && ((vals.hours != last_hours_q) ||
			(vals.minutes != last_minutes_q) || (vals.seconds != last_seconds_q));
	end

	assign raw_mask = changed & enable_q;

	// Keep only the first events in code order, up to the per-frame limit.
	always_comb begin
		kept_mask = '0;
		kept_cnt  = '0;
		for (int i = 0; i < NumSig; i++) begin
			if (raw_mask[i] && (kept_cnt < CntW'(MaxEvent))) begin
				kept_mask[i] = 1'b1;
				kept_cnt     = kept_cnt + 1'b1;
			end
		end
	end

	assign q_wr.valid       = accept && (kept_mask != '0);
	assign q_wr.entry.mask  = kept_mask;
	assign q_wr.entry.bytes = bytes;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_id_q <= 11'h233;
			state_id_q <= 11'h050;
			odo_id_q   <= 11'h0C4;
			freq_id_q  <= 11'h08F;
			pos_id_q   <= 11'h213;
			clk_id_q   <= 11'h0C7;
			enable_q   <= '1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SPEED_ID:     speed_id_q <= cfg_data;
				CFG_STATE_ID:     state_id_q <= cfg_data;
				CFG_ODOMETER_ID:  odo_id_q   <= cfg_data;
				CFG_FREQUENCY_ID: freq_id_q  <= cfg_data;
				CFG_POSITION_ID:  pos_id_q   <= cfg_data;
				CFG_CLOCK_ID:     clk_id_q   <= cfg_data;
				CFG_EVENT_ENABLE: enable_q   <= cfg_data[NumSig-1:0];
				default: ;
			endcase
		end
	end

	// Stored values follow every matching frame, enabled or not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_speed_q       <= '0;
			last_distance_q    <= '0;
			last_limit_q       <= '0;
			last_light_q       <= '0;
			last_frequency_q   <= '0;
			last_valve_state_q <= 1'b0;
			last_valve_key_q   <= 1'b0;
			last_latitude_q    <= '0;
			last_longitude_q   <= '0;
			last_hours_q       <= '0;
			last_minutes_q     <= '0;
			last_seconds_q     <= '0;
		end else if (accept) begin
			if (hit_speed) begin
				last_speed_q <= vals.speed;
			end
			if (hit_odo) begin
				last_distance_q <= vals.distance;
			end
			if (hit_state) begin
				last_limit_q       <= vals.limit;
				last_light_q       <= vals.light;
				last_valve_state_q <= vals.valve_state;
				last_valve_key_q   <= vals.valve_key;
			end
			if (hit_freq) begin
				last_frequency_q <= vals.frequency;
			end
			if (hit_pos) begin
				last_latitude_q  <= vals.latitude;
				last_longitude_q <= vals.longitude;
			end
			if (hit_clk) begin
				last_hours_q   <= vals.hours;
				last_minutes_q <= vals.minutes;
				last_seconds_q <= vals.seconds;
			end
		end
	end

	a_mask_limit: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr.valid |-> ($countones(q_wr.entry.mask) <= MaxEvent))
		else $error("front queued more events than one frame may carry");

endmodule

[rtl/cscd_queue.sv]
// Short FIFO of pending frames between the front end and the event sequencer.
// Depends on cscd_pkg for the entry type and depth.
module cscd_queue import cscd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  q_wr_t    q_wr,
	output logic     full,
	output logic     rd_valid,
	output q_entry_t rd_entry,
	input  logic     rd_pop
);

	q_entry_t         entries_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPtrW:0]   count_q;
	logic             do_push, do_pop;

	assign full     = (count_q == (QPtrW+1)'(QDepth));
	assign rd_valid = (count_q != '0);
	assign rd_entry = entries_q[rd_ptr_q];
	assign do_push  = q_wr.valid && !full;
	assign do_pop   = rd_pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= q_wr.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr.valid |-> !full)
		else $error("frame pushed into a full queue");

endmodule

[rtl/cscd_back.sv]
// Event sequencer: walks the head frame's pending-event mask, sends one change
// event per cycle while m_tready allows, via its output register. Uses cscd_pkg.
module cscd_back import cscd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  q_entry_t    q_entry,
	output logic        q_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,
	output logic [3:0]  m_tuser,
	output logic        m_tlast
);

	logic              cur_valid_q;
	logic [NumSig-1:0] rem_q;
	frame_bytes_t      bytes_q;

	logic              out_valid_q;
	logic [31:0]       out_a_q;
	logic [30:0]       out_b_q;
	logic [7:0]        out_c_q;
	logic [3:0]        out_sig_q;
	logic              out_last_q;

	frame_vals_t       vals;
	logic [3:0]        pick;
	logic [NumSig-1:0] pick_bit, rem_after;
	logic              is_last, out_free, emit;
	logic [31:0]       val_a;
	logic [30:0]       val_b;
	logic [7:0]        val_c;

	// Lowest pending code goes next.
	always_comb begin
		pick     = '0;
		pick_bit = '0;
		for (int i = NumSig - 1; i >= 0; i--) begin
			if (rem_q[i]) begin
				pick     = 4'(i);
				pick_bit = NumSig'(1) << i;
			end
		end
	end

	assign rem_after = rem_q & ~pick_bit;
	assign is_last   = (rem_after == '0);
	assign out_free  = !out_valid_q || m_tready;
	assign emit      = cur_valid_q && out_free;
	assign q_pop     = q_valid && (!cur_valid_q || (emit && is_last));

	assign vals = decode_frame(bytes_q);

	always_comb begin
		val_a = '0;
		val_b = '0;
		val_c = '0;
		case (sig_code_t'(pick))
			SIG_SPEED:       val_a = 32'(vals.speed);
			SIG_DISTANCE:    val_a = 32'(vals.distance);
			SIG_LIMIT:       val_a = 32'(vals.limit);
			SIG_LIGHT:       val_a = 32'(vals.light);
			SIG_FREQUENCY:   val_a = 32'(vals.frequency);
			SIG_VALVE_STATE: val_a = 32'(vals.valve_state);
			SIG_VALVE_KEY:   val_a = 32'(vals.valve_key);
			SIG_POSITION: begin
				val_a = vals.latitude;
				val_b = vals.longitude;
			end
			SIG_TIME: begin
				val_a = 32'(vals.hours);
				val_b = 31'(vals.minutes);
				val_c = vals.seconds;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			rem_q       <= '0;
		end else if (q_pop) begin
			cur_valid_q <= 1'b1;
			rem_q       <= q_entry.mask;
		end else if (emit) begin
			cur_valid_q <= !is_last;
			rem_q       <= rem_after;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			bytes_q <= q_entry.bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_sig_q  <= pick;
			out_a_q    <= val_a;
			out_b_q    <= val_b;
			out_c_q    <= val_c;
			out_last_q <= is_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_c_q, out_b_q, out_a_q};
	assign m_tuser  = out_sig_q;
	assign m_tlast  = out_last_q;

	a_busy_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (rem_q != '0))
		else $error("sequencer busy with an empty event mask");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (pick <= 4'(SIG_TIME)))
		else $error("event code out of range");

	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_valid_q && !emit) |-> !q_pop)
		else $error("new frame loaded while events of the previous one remain");

endmodule

[rtl/can_signal_change_decoder.sv]
// Top level of the CAN signal change decoder: front end, frame queue and event
// sequencer. Depends on cscd_pkg, cscd_front, cscd_queue and cscd_back.
//
//  Channel  Direction  Handshake              Payload
//  s_*      in         s_tvalid / s_tready    s_tdata: can_id, byte0..byte7
//  m_*      out        m_tvalid / m_tready    m_tdata: value_a, value_b, value_c;
//                                             m_tuser: signal; m_tlast: last
//  cfg_*    in         cfg_valid / cfg_ready  cfg_index: register, cfg_data: value
//
// A frame is matched, compared with the stored signal values and its change
// mask queued in the cycle of its transfer; stored values update at that edge.
// The sequencer sends one change event per cycle while the output accepts, so a
// frame's events go out back to back; frames without events are never queued.
// Frames keep being taken while the four-entry queue has room, so a stalled
// output only holds off input once the queue fills. Reset restores the default
// message IDs, enables all events and clears every stored value; cfg_ready is
// always high.
module can_signal_change_decoder import cscd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // [10:0] can_id, [18:11] byte0, [26:19] byte1,
	                               // ... [74:67] byte7, [79:75] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [31:0] value_a, [62:32] value_b, [70:63] value_c,
	                               // [71] zero
	output logic [3:0]  m_tuser,   // [3:0] signal
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	q_wr_t    q_wr;
	logic     q_full;
	logic     q_valid;
	q_entry_t q_entry;
	logic     q_pop;

	// Identifier match, change detection and the signal value registers.
	cscd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_wr      (q_wr)
	);

	// Frames that produce at least one event wait here for the sequencer.
	cscd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_wr     (q_wr),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_entry (q_entry),
		.rd_pop   (q_pop)
	);

	// One event per cycle while the output accepts, in signal-code order; the final
	// one of a frame is marked with m_tlast.
	cscd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_entry  (q_entry),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
